// ===== rtl/vfc_pkg.sv =====
// ----------------------------------------------------------------------------
// vfc_pkg
// Shared constants, codes and controller/datapath interface types for the
// voxel face culling block.
// ----------------------------------------------------------------------------
package vfc_pkg;

  localparam int SIZE_X      = 16;
  localparam int SIZE_Y      = 64;
  localparam int SIZE_Z      = 16;
  localparam int VOXEL_COUNT = SIZE_X * SIZE_Y * SIZE_Z;
  localparam int ADDR_W      = $clog2(VOXEL_COUNT);

  localparam int ID_W    = 14;
  localparam int IN_ID_W = 16;
  localparam int X_W     = 4;
  localparam int Y_W     = 6;
  localparam int Z_W     = 4;
  localparam int DIR_W   = 3;
  localparam int ACT_W   = 2;
  localparam int NUM_DIR = 6;

  localparam logic [ID_W-1:0] ID_RESET = ID_W'(255);

  localparam logic [ACT_W-1:0] ACT_WRITE = 2'd0;
  localparam logic [ACT_W-1:0] ACT_MESH  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

  localparam logic [DIR_W-1:0] DIR_BOTTOM = 3'd0;
  localparam logic [DIR_W-1:0] DIR_TOP    = 3'd1;
  localparam logic [DIR_W-1:0] DIR_EAST   = 3'd2;
  localparam logic [DIR_W-1:0] DIR_WEST   = 3'd3;
  localparam logic [DIR_W-1:0] DIR_SOUTH  = 3'd4;
  localparam logic [DIR_W-1:0] DIR_NORTH  = 3'd5;

  typedef struct packed {
    logic             load_in;
    logic             wr_center;
    logic             sweep;
    logic             nb_read;
    logic [DIR_W-1:0] nb_dir;
    logic             load_blk;
    logic             cap_vis;
    logic             emit;
  } vfc_cmd_t;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic             in_chunk;
    logic             center_air;
    logic             sweep_done;
    logic             vis_any;
    logic             vis_last;
    logic             out_free;
  } vfc_sts_t;

endpackage

// ===== rtl/voxel_face_culling.sv =====
// ----------------------------------------------------------------------------
// voxel_face_culling
// Hidden-face culling over one voxel chunk held in a single-port store.
// ----------------------------------------------------------------------------
// sequence: write decodes, then stores the center; mesh reads the center (air ends it),
//   then each neighbor, then emits faces as out_ready allows; clear zeroes the store
// throughput: one item at a time, bound by the single store port that reads
//   the center voxel and then each of the six neighbors in turn
// reset: synchronous rst_n, then a zeroing pass over the whole store
//   with in_ready low; configuration writes are taken throughout
module voxel_face_culling
  import vfc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [ACT_W-1:0]   in_action,
  input  logic [X_W-1:0]     in_pos_x,
  input  logic [Y_W-1:0]     in_pos_y,
  input  logic [Z_W-1:0]     in_pos_z,
  input  logic [IN_ID_W-1:0] in_new_block,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [X_W-1:0]     out_face_x,
  output logic [Y_W-1:0]     out_face_y,
  output logic [Z_W-1:0]     out_face_z,
  output logic [DIR_W-1:0]   out_face_dir,
  output logic [ID_W-1:0]    out_face_block,
  output logic               out_last_face
);

  vfc_cmd_t        cmd;
  vfc_sts_t        sts;
  logic [ID_W-1:0] unknown_id;

  vfc_regs u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .unknown_id (unknown_id)
  );

  vfc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  vfc_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .unknown_id     (unknown_id),
    .in_action      (in_action),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_pos_z       (in_pos_z),
    .in_new_block   (in_new_block),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_face_x     (out_face_x),
    .out_face_y     (out_face_y),
    .out_face_z     (out_face_z),
    .out_face_dir   (out_face_dir),
    .out_face_block (out_face_block),
    .out_last_face  (out_last_face)
  );

endmodule

// ===== rtl/vfc_regs.sv =====
// ----------------------------------------------------------------------------
// vfc_regs
// APB-style configuration register holding the unknown block id.
// ----------------------------------------------------------------------------
module vfc_regs
  import vfc_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [2:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready,
  output logic [ID_W-1:0] unknown_id
);

  logic [ID_W-1:0] unknown_id_r;
  logic            wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && !paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unknown_id_r <= ID_RESET;
    end else if (wr_en) begin
      unknown_id_r <= pwdata[ID_W-1:0];
    end
  end

  assign unknown_id = unknown_id_r;
  assign prdata     = paddr[2] ? 32'd0 : {{(32-ID_W){1'b0}}, unknown_id_r};

endmodule

// ===== rtl/vfc_dp.sv =====
// ----------------------------------------------------------------------------
// vfc_dp
// Datapath: voxel store, neighbor addressing, visibility mask and the
// face output register.
// ----------------------------------------------------------------------------
module vfc_dp
  import vfc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  vfc_cmd_t           cmd,
  output vfc_sts_t           sts,
  input  logic [ID_W-1:0]    unknown_id,
  input  logic [ACT_W-1:0]   in_action,
  input  logic [X_W-1:0]     in_pos_x,
  input  logic [Y_W-1:0]     in_pos_y,
  input  logic [Z_W-1:0]     in_pos_z,
  input  logic [IN_ID_W-1:0] in_new_block,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [X_W-1:0]     out_face_x,
  output logic [Y_W-1:0]     out_face_y,
  output logic [Z_W-1:0]     out_face_z,
  output logic [DIR_W-1:0]   out_face_dir,
  output logic [ID_W-1:0]    out_face_block,
  output logic               out_last_face
);

  localparam logic [ADDR_W-1:0] STRIDE_X  = ADDR_W'(1);
  localparam logic [ADDR_W-1:0] STRIDE_Z  = ADDR_W'(SIZE_X);
  localparam logic [ADDR_W-1:0] STRIDE_Y  = ADDR_W'(SIZE_X * SIZE_Z);
  localparam logic [ADDR_W-1:0] SWEEP_END = ADDR_W'(VOXEL_COUNT - 1);

  logic [ID_W-1:0]    mem [VOXEL_COUNT];
  logic [ID_W-1:0]    rdata_r;

  logic [X_W-1:0]     x_r;
  logic [Y_W-1:0]     y_r;
  logic [Z_W-1:0]     z_r;
  logic [ACT_W-1:0]   act_r;
  logic [ID_W-1:0]    id_r;
  logic               inside_r;
  logic [ID_W-1:0]    blk_r;
  logic [NUM_DIR-1:0] vis_r;
  logic [DIR_W-1:0]   dir_q_r;
  logic [ADDR_W-1:0]  sweep_cnt_r;

  logic               out_valid_r;
  logic [X_W-1:0]     out_x_r;
  logic [Y_W-1:0]     out_y_r;
  logic [Z_W-1:0]     out_z_r;
  logic [DIR_W-1:0]   out_dir_r;
  logic [ID_W-1:0]    out_blk_r;
  logic               out_last_r;

  logic [ADDR_W-1:0]  center;
  logic [ADDR_W-1:0]  nb_addr;
  logic [ADDR_W-1:0]  addr;
  logic               we;
  logic [ID_W-1:0]    wdata;
  logic [NUM_DIR-1:0] inb;
  logic [DIR_W-1:0]   sel_dir;
  logic               in_inside;

  assign in_inside = (int'(in_pos_x) < SIZE_X) && (int'(in_pos_y) < SIZE_Y)
                     && (int'(in_pos_z) < SIZE_Z);

  assign center = ADDR_W'(x_r) + ADDR_W'(z_r) * STRIDE_Z + ADDR_W'(y_r) * STRIDE_Y;

  always_comb begin
    case (cmd.nb_dir)
      DIR_BOTTOM: nb_addr = center - STRIDE_Y;
      DIR_TOP:    nb_addr = center + STRIDE_Y;
      DIR_EAST:   nb_addr = center - STRIDE_X;
      DIR_WEST:   nb_addr = center + STRIDE_X;
      DIR_SOUTH:  nb_addr = center - STRIDE_Z;
      DIR_NORTH:  nb_addr = center + STRIDE_Z;
      default:    nb_addr = center;
    endcase
  end

  always_comb begin
    inb[DIR_BOTTOM] = y_r != '0;
    inb[DIR_TOP]    = (int'(y_r) + 1) < SIZE_Y;
    inb[DIR_EAST]   = x_r != '0;
    inb[DIR_WEST]   = (int'(x_r) + 1) < SIZE_X;
    inb[DIR_SOUTH]  = z_r != '0;
    inb[DIR_NORTH]  = (int'(z_r) + 1) < SIZE_Z;
  end

  always_comb begin
    if (cmd.sweep) begin
      addr = sweep_cnt_r;
    end else if (cmd.nb_read) begin
      addr = nb_addr;
    end else begin
      addr = center;
    end
    we    = cmd.sweep || cmd.wr_center;
    wdata = cmd.sweep ? '0 : id_r;
  end

  // single-port store, read-first, registered read data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  always_comb begin
    sel_dir = DIR_BOTTOM;
    for (int i = NUM_DIR - 1; i >= 0; i--) begin
      if (vis_r[i]) begin
        sel_dir = DIR_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      x_r      <= in_pos_x;
      y_r      <= in_pos_y;
      z_r      <= in_pos_z;
      act_r    <= in_action;
      id_r     <= in_new_block[ID_W-1:0];
      inside_r <= in_inside;
    end
    if (cmd.load_blk) begin
      blk_r <= (rdata_r > unknown_id) ? unknown_id : rdata_r;
      vis_r <= '0;
    end else if (cmd.cap_vis) begin
      vis_r[dir_q_r] <= inb[dir_q_r] && (rdata_r == '0);
    end else if (cmd.emit) begin
      vis_r[sel_dir] <= 1'b0;
    end
    dir_q_r <= cmd.nb_dir;
    if (cmd.emit) begin
      out_x_r    <= x_r;
      out_y_r    <= y_r;
      out_z_r    <= z_r;
      out_dir_r  <= sel_dir;
      out_blk_r  <= blk_r;
      out_last_r <= $onehot(vis_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.sweep && (sweep_cnt_r != SWEEP_END)) begin
        sweep_cnt_r <= sweep_cnt_r + ADDR_W'(1);
      end else begin
        sweep_cnt_r <= '0;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // face record held until its transfer, apart from the next request
  assign out_valid      = out_valid_r;
  assign out_face_x     = out_x_r;
  assign out_face_y     = out_y_r;
  assign out_face_z     = out_z_r;
  assign out_face_dir   = out_dir_r;
  assign out_face_block = out_blk_r;
  assign out_last_face  = out_last_r;

  assign sts.action     = act_r;
  assign sts.in_chunk   = inside_r;
  assign sts.center_air = rdata_r == '0;
  assign sts.sweep_done = sweep_cnt_r == SWEEP_END;
  assign sts.vis_any    = vis_r != '0;
  assign sts.vis_last   = $onehot(vis_r);
  assign sts.out_free   = !out_valid_r || out_ready;

endmodule

// ===== rtl/vfc_ctrl.sv =====
// ----------------------------------------------------------------------------
// vfc_ctrl
// Controller: sequences store sweeps, writes, the center and neighbor reads
// of a mesh request, and face emission.
// ----------------------------------------------------------------------------
module vfc_ctrl
  import vfc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output vfc_cmd_t cmd,
  input  vfc_sts_t sts
);

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_DEC,
    S_CHK,
    S_NB,
    S_EMIT
  } state_t;

  state_t           state_r, state_nxt;
  logic [DIR_W-1:0] dir_r, dir_nxt;

  always_comb begin
    state_nxt = state_r;
    dir_nxt   = dir_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_CLR: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_DEC;
        end
      end
      S_DEC: begin
        case (sts.action)
          ACT_WRITE: begin
            cmd.wr_center = sts.in_chunk;
            state_nxt     = S_IDLE;
          end
          ACT_MESH: begin
            state_nxt = sts.in_chunk ? S_CHK : S_IDLE;
          end
          ACT_CLEAR: begin
            state_nxt = S_CLR;
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_CHK: begin
        if (sts.center_air) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.load_blk = 1'b1;
          cmd.nb_read  = 1'b1;
          cmd.nb_dir   = DIR_BOTTOM;
          dir_nxt      = DIR_BOTTOM;
          state_nxt    = S_NB;
        end
      end
      S_NB: begin
        cmd.cap_vis = 1'b1;
        cmd.nb_read = 1'b1;
        cmd.nb_dir  = dir_r + DIR_W'(1);
        dir_nxt     = dir_r + DIR_W'(1);
        if (dir_r == DIR_NORTH) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!sts.vis_any) begin
          state_nxt = S_IDLE;
        end else if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.vis_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      dir_r   <= DIR_BOTTOM;
    end else begin
      state_r <= state_nxt;
      dir_r   <= dir_nxt;
    end
  end

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free && sts.vis_any)
    else $error("face emitted without a free output register");

  a_no_write_in_mesh: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHK || state_r == S_NB || state_r == S_EMIT) |-> !cmd.sweep && !cmd.wr_center)
    else $error("store written during a mesh request");

  a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.sweep || cmd.nb_read || cmd.emit) |-> !in_ready)
    else $error("input ready while busy");

  a_emit_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_NB && dir_r == DIR_NORTH) |=> state_r == S_EMIT)
    else $error("neighbor scan did not end in emission");

endmodule

// ===== tb/sv/tb_voxel_face_culling.sv =====
// ----------------------------------------------------------------------------
// tb_voxel_face_culling
// Self-checking bench for the voxel face culling block. A local copy of the
// chunk store and the unknown id register predicts every face record. Face
// records are compared field by field, in order, as they leave the block.
// Directed boundary and masking cases run first, then clamp-register phases,
// then random clusters of writes and mesh queries with noise and clears.
// Both channels get random gaps and back-pressure.
// ----------------------------------------------------------------------------
module tb_voxel_face_culling
  import vfc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0]       UNKNOWN_ID_ADDR = 3'd0;
  localparam logic [ACT_W-1:0] ACT_UNUSED      = 2'd3;
  localparam int MAX_GAP      = 14;
  localparam int IDLE_SETTLE  = 24;
  localparam int CLEAR_SETTLE = VOXEL_COUNT + 16;
  localparam int RANDOM_ITEMS = 340;

  typedef struct packed {
    logic [X_W-1:0]   x;
    logic [Y_W-1:0]   y;
    logic [Z_W-1:0]   z;
    logic [DIR_W-1:0] dir;
    logic [ID_W-1:0]  blk;
    logic             last;
  } face_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [ACT_W-1:0]   in_action = '0;
  logic [X_W-1:0]     in_pos_x = '0;
  logic [Y_W-1:0]     in_pos_y = '0;
  logic [Z_W-1:0]     in_pos_z = '0;
  logic [IN_ID_W-1:0] in_new_block = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [X_W-1:0]     out_face_x;
  logic [Y_W-1:0]     out_face_y;
  logic [Z_W-1:0]     out_face_z;
  logic [DIR_W-1:0]   out_face_dir;
  logic [ID_W-1:0]    out_face_block;
  logic               out_last_face;

  logic [ID_W-1:0] voxel_ids [VOXEL_COUNT];
  logic [ID_W-1:0] unknown_id;
  face_t           faces_due[$];
  int              errors = 0;
  int              items_sent = 0;
  int              rx_hold = 0;
  bit              rx_took = 1'b0;
  bit              steady = 1'b0;
  bit              clear_pending = 1'b0;

  voxel_face_culling uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_pos_z       (in_pos_z),
    .in_new_block   (in_new_block),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_face_x     (out_face_x),
    .out_face_y     (out_face_y),
    .out_face_z     (out_face_z),
    .out_face_dir   (out_face_dir),
    .out_face_block (out_face_block),
    .out_last_face  (out_last_face)
  );

  always #1 clk = ~clk;

  task automatic report(string what);
    $display("mismatch at %0t ns: %s", $time, what);
    errors++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      report($sformatf("%s got %0d expected %0d", name, got, want));
    end
  endtask

  function automatic int pause_len();
    return steady ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  function automatic int voxel_addr(int x, int y, int z);
    return x + z * SIZE_X + y * SIZE_X * SIZE_Z;
  endfunction

  function automatic logic air_at(int x, int y, int z);
    if (x < 0 || y < 0 || z < 0 || x >= SIZE_X || y >= SIZE_Y || z >= SIZE_Z) begin
      return 1'b0;
    end
    return voxel_ids[voxel_addr(x, y, z)] == '0;
  endfunction

  // chunk store update and face prediction for one accepted transfer
  task automatic predict_item(logic [ACT_W-1:0] act, logic [X_W-1:0] x, logic [Y_W-1:0] y,
                              logic [Z_W-1:0] z, logic [IN_ID_W-1:0] nb);
    face_t           f;
    face_t           run[$];
    logic [ID_W-1:0] blk;
    logic            seen;
    int              xi;
    int              yi;
    int              zi;
    xi = x;
    yi = y;
    zi = z;
    case (act)
      ACT_CLEAR: begin
        foreach (voxel_ids[i]) voxel_ids[i] = '0;
        clear_pending = 1'b1;
      end
      ACT_WRITE: begin
        voxel_ids[voxel_addr(xi, yi, zi)] = nb[ID_W-1:0];
      end
      ACT_MESH: begin
        blk = voxel_ids[voxel_addr(xi, yi, zi)];
        if (blk != '0) begin
          if (blk > unknown_id) blk = unknown_id;
          for (int d = 0; d < NUM_DIR; d++) begin
            case (DIR_W'(d))
              DIR_BOTTOM: seen = yi > 0 && air_at(xi, yi - 1, zi);
              DIR_TOP:    seen = yi < SIZE_Y - 1 && air_at(xi, yi + 1, zi);
              DIR_EAST:   seen = xi > 0 && air_at(xi - 1, yi, zi);
              DIR_WEST:   seen = xi < SIZE_X - 1 && air_at(xi + 1, yi, zi);
              DIR_SOUTH:  seen = zi > 0 && air_at(xi, yi, zi - 1);
              DIR_NORTH:  seen = zi < SIZE_Z - 1 && air_at(xi, yi, zi + 1);
              default:    seen = 1'b0;
            endcase
            if (seen) begin
              f.x = x;
              f.y = y;
              f.z = z;
              f.dir = DIR_W'(d);
              f.blk = blk;
              f.last = 1'b0;
              run.push_back(f);
            end
          end
          if (run.size() > 0) run[run.size() - 1].last = 1'b1;
          foreach (run[i]) faces_due.push_back(run[i]);
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic send_item(logic [ACT_W-1:0] act, int x, int y, int z, int nb);
    int gap;
    gap = pause_len();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_action = act;
    in_pos_x = X_W'(x);
    in_pos_y = Y_W'(y);
    in_pos_z = Z_W'(z);
    in_new_block = IN_ID_W'(nb);
    do @(posedge clk); while (!in_ready);
    predict_item(in_action, in_pos_x, in_pos_y, in_pos_z, in_new_block);
    if (act != ACT_UNUSED) items_sent++;
  endtask

  // drop valid, wait out every pending face, then let the block go idle
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (faces_due.size() != 0) @(posedge clk);
    repeat (clear_pending ? CLEAR_SETTLE : IDLE_SETTLE) @(posedge clk);
    clear_pending = 1'b0;
  endtask

  task automatic cfg_unknown_id(logic [ID_W-1:0] v);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = UNKNOWN_ID_ADDR;
    pwdata = 32'(v);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    unknown_id = v;
    @(negedge clk);
    penable = 1'b0;
    pwrite = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    check_field("unknown_block_id readback", 32'(prdata[ID_W-1:0]), 32'(v));
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  function automatic int pick_coord(int maxv);
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return maxv;
      default: return $urandom_range(0, maxv);
    endcase
  endfunction

  function automatic int nudge(int v, int maxv);
    int r;
    r = v + $urandom_range(0, 2) - 1;
    if (r < 0) r = 0;
    if (r > maxv) r = maxv;
    return r;
  endfunction

  function automatic int pick_id();
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom_range(1, 600);
      4, 5, 6:    v = $urandom_range(0, 65535);
      7:          v = $urandom_range(0, 3) << ID_W;
      default:    v = int'(unknown_id) + $urandom_range(0, 2) - 1;
    endcase
    return (v < 0) ? 0 : v;
  endfunction

  function automatic logic [ID_W-1:0] pick_level();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return ID_W'($urandom_range(1, 16382));
    endcase
  endfunction

  always @(posedge clk) begin
    face_t want;
    if (rst_n && out_valid && out_ready) begin
      rx_took = 1'b1;
      if (faces_due.size() == 0) begin
        report($sformatf("unexpected face x=%0d y=%0d z=%0d dir=%0d",
                         out_face_x, out_face_y, out_face_z, out_face_dir));
      end else begin
        want = faces_due.pop_front();
        check_field("face_x", 32'(out_face_x), 32'(want.x));
        check_field("face_y", 32'(out_face_y), 32'(want.y));
        check_field("face_z", 32'(out_face_z), 32'(want.z));
        check_field("face_dir", 32'(out_face_dir), 32'(want.dir));
        check_field("face_block", 32'(out_face_block), 32'(want.blk));
        check_field("last_face", 32'(out_last_face), 32'(want.last));
      end
    end
  end

  // back-pressure after each face transfer
  always @(negedge clk) begin
    if (rx_took) begin
      rx_took = 1'b0;
      rx_hold = pause_len();
    end
    if (rx_hold > 0) begin
      out_ready <= 1'b0;
      rx_hold--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic test_boundary_faces();
    send_item(ACT_WRITE, 0, 0, 0, 'hFFFF);
    send_item(ACT_MESH, 0, 0, 0, 0);
    send_item(ACT_WRITE, 15, 63, 15, 5);
    send_item(ACT_MESH, 15, 63, 15, 'hFFFF);
    send_item(ACT_WRITE, 7, 31, 8, 300);
    send_item(ACT_MESH, 7, 31, 8, 0);
    send_item(ACT_MESH, 7, 32, 8, 0);
    send_item(ACT_WRITE, 7, 30, 8, 1);
    send_item(ACT_WRITE, 8, 31, 8, 'hC001);
    send_item(ACT_MESH, 7, 31, 8, 0);
    send_item(ACT_UNUSED, 7, 31, 8, 0);
    send_item(ACT_MESH, 7, 31, 8, 0);
    send_item(ACT_WRITE, 7, 31, 8, 'h4000);
    send_item(ACT_MESH, 7, 31, 8, 0);
    send_item(ACT_WRITE, 7, 31, 8, 255);
    send_item(ACT_MESH, 7, 31, 8, 0);
    send_item(ACT_WRITE, 1, 0, 0, 256);
    send_item(ACT_MESH, 1, 0, 0, 0);
    send_item(ACT_CLEAR, 15, 63, 15, 'hFFFF);
    send_item(ACT_MESH, 0, 0, 0, 0);
    send_item(ACT_MESH, 15, 63, 15, 0);
  endtask

  task automatic test_unknown_id_clamp();
    logic [ID_W-1:0] levels [4];
    levels = '{'0, '1, ID_W'(1), ID_RESET};
    foreach (levels[i]) begin
      settle();
      cfg_unknown_id(levels[i]);
      steady = (i % 2 == 0);
      send_item(ACT_WRITE, 3, 10, 3, int'(levels[i]) + 1);
      send_item(ACT_MESH, 3, 10, 3, 0);
      send_item(ACT_WRITE, 3, 10, 3, 'h3FFF);
      send_item(ACT_MESH, 3, 10, 3, 0);
    end
    steady = 1'b0;
  endtask

  task automatic test_random_chunks();
    int stop_at;
    int clears_left;
    int cx;
    int cy;
    int cz;
    int k;
    int px[$];
    int py[$];
    int pz[$];
    stop_at = items_sent + RANDOM_ITEMS;
    clears_left = 2;
    while (items_sent < stop_at) begin
      steady = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) == 0) begin
        settle();
        cfg_unknown_id(pick_level());
      end
      if (clears_left > 0 && $urandom_range(0, 24) == 0) begin
        send_item(ACT_CLEAR, $urandom_range(0, 15), $urandom_range(0, 63),
                  $urandom_range(0, 15), $urandom_range(0, 65535));
        clears_left--;
      end
      cx = pick_coord(SIZE_X - 1);
      cy = pick_coord(SIZE_Y - 1);
      cz = pick_coord(SIZE_Z - 1);
      px.delete();
      py.delete();
      pz.delete();
      repeat ($urandom_range(2, 8)) begin
        px.push_back(nudge(cx, SIZE_X - 1));
        py.push_back(nudge(cy, SIZE_Y - 1));
        pz.push_back(nudge(cz, SIZE_Z - 1));
        send_item(ACT_WRITE, px[$], py[$], pz[$], pick_id());
      end
      repeat ($urandom_range(2, 6)) begin
        if ($urandom_range(0, 3) == 0) begin
          send_item(ACT_MESH, nudge(cx, SIZE_X - 1), nudge(cy, SIZE_Y - 1),
                    nudge(cz, SIZE_Z - 1), $urandom_range(0, 65535));
        end else begin
          k = $urandom_range(0, px.size() - 1);
          send_item(ACT_MESH, px[k], py[k], pz[k], $urandom_range(0, 65535));
        end
      end
      if ($urandom_range(0, 2) == 0) begin
        k = $urandom_range(0, 3);
        if (ACT_W'(k) == ACT_CLEAR) k = $urandom_range(0, 1);
        send_item(ACT_W'(k), $urandom_range(0, 15), $urandom_range(0, 63),
                  $urandom_range(0, 15), $urandom_range(0, 65535));
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    foreach (voxel_ids[i]) voxel_ids[i] = '0;
    unknown_id = ID_RESET;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_boundary_faces();
    test_unknown_id_clamp();
    test_random_chunks();
    settle();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
